@@ src/lcg_with_conditioned_params_core_assert.svh @@
// assertion macros shared by the lcg core modules
// expects clk and rst_n to be visible at the point of use
`ifndef LCG_WITH_CONDITIONED_PARAMS_CORE_ASSERT_SVH
`define LCG_WITH_CONDITIONED_PARAMS_CORE_ASSERT_SVH

// same-cycle implication
`define LCGC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lcgc: same-cycle check failed");

// next-cycle implication
`define LCGC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lcgc: next-cycle check failed");

`endif

@@ src/lcgc_pkg.sv @@
// package for the lcg core: widths, codes, reset values and the
// command and status structs between controller and datapath; no dependencies
`default_nettype none

package lcgc_pkg;

    localparam int MOD_W  = 17;
    localparam int RAW_W  = 32;
    localparam int SUM_W  = 48;
    localparam int POS_W  = 16;
    localparam int NUM_W  = 16;
    localparam int CHAR_W = 8;
    localparam int OP_W   = 2;
    localparam int COND_W = MOD_W + 1;
    localparam int PROD_W = 2 * MOD_W;
    localparam int CNT_W  = 6;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam int STATE_BITS_DEF = 16;

    localparam logic [MOD_W-1:0] MOD_RESET    = 17'd32768;
    localparam logic [RAW_W-1:0] FACTOR_RESET = 32'd36739;
    localparam logic [RAW_W-1:0] INCR_RESET   = 32'd17389;

    localparam int FactorFloor = 4000;
    localparam int IncrFloor   = 3000;

    localparam logic [OP_W-1:0] OP_NEXT = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD = 2'd1;
    localparam logic [OP_W-1:0] OP_SEED = 2'd2;

    localparam logic [1:0] REG_MODULUS = 2'd0;
    localparam logic [1:0] REG_FACTOR  = 2'd1;
    localparam logic [1:0] REG_INCR    = 2'd2;

    // dividend source for the remainder unit
    typedef enum logic [2:0] {
        SRC_FACTOR = 3'd0,
        SRC_A_COND = 3'd1,
        SRC_INCR   = 3'd2,
        SRC_C_COND = 3'd3,
        SRC_CUR    = 3'd4,
        SRC_PROD   = 3'd5,
        SRC_VALUE  = 3'd6,
        SRC_SEED   = 3'd7
    } src_t;

    typedef enum logic [2:0] {
        DP_NONE   = 3'd0,
        DP_SAVE_A = 3'd1,
        DP_SAVE_C = 3'd2,
        DP_MUL    = 3'd3,
        DP_ADD    = 3'd4,
        DP_FIN    = 3'd5,
        DP_SEED   = 3'd6
    } dp_op_t;

    typedef struct packed {
        logic   capture;
        logic   div_start;
        src_t   src;
        dp_op_t dp_op;
        logic   out_load;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic last;
    } stat_t;

endpackage

`default_nettype wire

@@ src/lcgc_ctrl.sv @@
// sequencing state machine of the lcg core
// depends on lcgc_pkg and the assertion macro header
`default_nettype none
`include "lcg_with_conditioned_params_core_assert.svh"

module lcgc_ctrl
    import lcgc_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic [OP_W-1:0] op,
    output logic                 out_valid,
    input  wire logic            out_ready,
    input  wire stat_t           stat,
    output cmd_t                 cmd
);

    typedef enum logic [13:0] {
        S_IDLE = 14'b00000000000001,
        S_FA   = 14'b00000000000010,
        S_CA   = 14'b00000000000100,
        S_FI   = 14'b00000000001000,
        S_CI   = 14'b00000000010000,
        S_FX   = 14'b00000000100000,
        S_MUL  = 14'b00000001000000,
        S_PR   = 14'b00000010000000,
        S_ADD  = 14'b00000100000000,
        S_LD   = 14'b00001000000000,
        S_SEED = 14'b00010000000000,
        S_FIN  = 14'b00100000000000,
        S_WAIT = 14'b01000000000000,
        S_OUT  = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;
    logic   out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        cmd.capture   = 1'b0;
        cmd.div_start = 1'b0;
        cmd.src       = SRC_FACTOR;
        cmd.dp_op     = DP_NONE;
        cmd.out_load  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    priority if (op == OP_NEXT)
                        state_next = S_FA;
                    else if (op == OP_LOAD)
                        state_next = S_LD;
                    else if (op == OP_SEED)
                        state_next = S_SEED;
                    else
                        state_next = S_OUT;
                end
            end
            S_FA:
            begin
                cmd.div_start = 1'b1;
                cmd.src       = SRC_FACTOR;
                ret_next      = S_CA;
                state_next    = S_WAIT;
            end
            S_CA:
            begin
                cmd.div_start = 1'b1;
                cmd.src       = SRC_A_COND;
                ret_next      = S_FI;
                state_next    = S_WAIT;
            end
            S_FI:
            begin
                cmd.dp_op     = DP_SAVE_A;
                cmd.div_start = 1'b1;
                cmd.src       = SRC_INCR;
                ret_next      = S_CI;
                state_next    = S_WAIT;
            end
            S_CI:
            begin
                cmd.div_start = 1'b1;
                cmd.src       = SRC_C_COND;
                ret_next      = S_FX;
                state_next    = S_WAIT;
            end
            S_FX:
            begin
                cmd.dp_op     = DP_SAVE_C;
                cmd.div_start = 1'b1;
                cmd.src       = SRC_CUR;
                ret_next      = S_MUL;
                state_next    = S_WAIT;
            end
            S_MUL:
            begin
                cmd.dp_op  = DP_MUL;
                state_next = S_PR;
            end
            S_PR:
            begin
                cmd.div_start = 1'b1;
                cmd.src       = SRC_PROD;
                ret_next      = S_ADD;
                state_next    = S_WAIT;
            end
            S_ADD:
            begin
                cmd.dp_op  = DP_ADD;
                state_next = S_OUT;
            end
            S_LD:
            begin
                cmd.div_start = 1'b1;
                cmd.src       = SRC_VALUE;
                ret_next      = S_FIN;
                state_next    = S_WAIT;
            end
            S_SEED:
            begin
                cmd.dp_op = DP_SEED;
                if (stat.last)
                begin
                    cmd.div_start = 1'b1;
                    cmd.src       = SRC_SEED;
                    ret_next      = S_FIN;
                    state_next    = S_WAIT;
                end
                else
                    state_next = S_OUT;
            end
            S_FIN:
            begin
                cmd.dp_op  = DP_FIN;
                state_next = S_OUT;
            end
            S_WAIT:
            begin
                if (stat.div_done)
                    state_next = ret_reg;
            end
            S_OUT:
            begin
                // hold here only while the previous word is still not taken
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `LCGC_ASSERT_NXT(a_accept_leaves_idle, in_valid && in_ready, state_reg != S_IDLE)
    `LCGC_ASSERT_NXT(a_wait_return, (state_reg == S_WAIT) && stat.div_done, state_reg == $past(ret_reg))
    `LCGC_ASSERT_NXT(a_out_load_valid, cmd.out_load, out_valid_reg)

endmodule

`default_nettype wire

@@ src/lcgc_datapath.sv @@
// datapath of the lcg core: word capture, bit-serial remainder unit,
// parameter conditioning, multiplier, seed accumulator; depends on lcgc_pkg
`default_nettype none
`include "lcg_with_conditioned_params_core_assert.svh"

module lcgc_datapath
    import lcgc_pkg::*;
#(
    parameter int STATE_BITS = STATE_BITS_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cmd_t              cmd,
    output stat_t                  stat,
    input  wire logic [MOD_W-1:0]  modulus,
    input  wire logic [RAW_W-1:0]  factor_raw,
    input  wire logic [RAW_W-1:0]  increment_raw,
    input  wire logic [RAW_W-1:0]  value,
    input  wire logic [CHAR_W-1:0] character,
    input  wire logic              first,
    input  wire logic              last,
    output logic [NUM_W-1:0]       number
);

    localparam int TOP_W = 33;
    localparam logic [TOP_W-1:0] TOP = TOP_W'(1) << STATE_BITS;

    logic [RAW_W-1:0]      value_reg;
    logic [CHAR_W-1:0]     char_reg;
    logic                  first_reg;
    logic                  last_reg;

    logic [STATE_BITS-1:0] current_reg, current_next;
    logic [SUM_W-1:0]      seed_sum_reg;
    logic [POS_W-1:0]      pos_reg;

    logic [SUM_W-1:0]      dvd_reg, dvd_next;
    logic [MOD_W-1:0]      rem_reg, rem_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;

    logic [MOD_W-1:0]      a_reg;
    logic [MOD_W-1:0]      c_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic [NUM_W-1:0]      number_reg;

    logic [MOD_W-1:0]      m;
    logic [COND_W-1:0]     m_ext;

    // effective modulus: clamped to 2 .. 2^STATE_BITS
    always_comb
    begin
        priority if (modulus < MOD_W'(2))
            m = MOD_W'(2);
        else if ({{(TOP_W-MOD_W){1'b0}}, modulus} > TOP)
            m = TOP[MOD_W-1:0];
        else
            m = modulus;
    end

    assign m_ext = {1'b0, m};

    // conditioned multiplier from factor_raw mod m held in rem_reg
    logic [1:0]        a_step;
    logic [COND_W-1:0] a_sum, a_red, cond_a;

    always_comb
    begin
        unique case (rem_reg[1:0])
            2'd0: a_step = 2'd1;
            2'd1: a_step = 2'd0;
            2'd2: a_step = 2'd3;
            2'd3: a_step = 2'd2;
        endcase
        a_sum  = {1'b0, rem_reg} + COND_W'(a_step);
        a_red  = (a_sum >= m_ext) ? a_sum - m_ext : a_sum;
        cond_a = (a_red < COND_W'(FactorFloor)) ? a_red + COND_W'(FactorFloor) : a_red;
    end

    // conditioned increment from increment_raw mod m held in rem_reg
    logic [COND_W-1:0] c_sum, c_red, cond_c;

    always_comb
    begin
        c_sum  = {1'b0, rem_reg} + COND_W'(!rem_reg[0]);
        c_red  = (c_sum >= m_ext) ? c_sum - m_ext : c_sum;
        cond_c = (c_red < COND_W'(IncrFloor)) ? c_red + COND_W'(IncrFloor) : c_red;
    end

    // seed accumulation
    logic [CHAR_W-1:0]  mag;
    logic [SUM_W-1:0]   base_sum, sum_new;
    logic [POS_W-1:0]   base_pos, pos_new;
    logic [POS_W:0]     weight;
    logic [POS_W+CHAR_W:0] term;

    always_comb
    begin
        mag      = char_reg[CHAR_W-1] ? (~char_reg + CHAR_W'(1)) : char_reg;
        base_sum = first_reg ? SUM_W'(1) : seed_sum_reg;
        base_pos = first_reg ? '0 : pos_reg;
        weight   = {1'b0, base_pos} + (POS_W+1)'(1);
        term     = {{CHAR_W{1'b0}}, weight} * {{(POS_W+1){1'b0}}, mag};
        sum_new  = base_sum + {{(SUM_W-POS_W-CHAR_W-1){1'b0}}, term};
        pos_new  = (base_pos == '1) ? base_pos : base_pos + POS_W'(1);
    end

    // remainder unit: one dividend bit per cycle, msb first
    logic [COND_W-1:0] rem_shift, rem_red;

    always_comb
    begin
        rem_shift = {rem_reg, dvd_reg[SUM_W-1]};
        rem_red   = (rem_shift >= m_ext) ? rem_shift - m_ext : rem_shift;
        rem_next  = rem_red[MOD_W-1:0];
        dvd_next  = {dvd_reg[SUM_W-2:0], 1'b0};
        cnt_next  = cnt_reg - CNT_W'(1);
    end

    // dividend alignment per source
    logic [SUM_W-1:0] load_dvd;
    logic [CNT_W-1:0] load_cnt;

    always_comb
    begin
        unique case (cmd.src)
            SRC_FACTOR:
            begin
                load_dvd = {factor_raw, {(SUM_W-RAW_W){1'b0}}};
                load_cnt = CNT_W'(RAW_W);
            end
            SRC_A_COND:
            begin
                load_dvd = {cond_a, {(SUM_W-COND_W){1'b0}}};
                load_cnt = CNT_W'(COND_W);
            end
            SRC_INCR:
            begin
                load_dvd = {increment_raw, {(SUM_W-RAW_W){1'b0}}};
                load_cnt = CNT_W'(RAW_W);
            end
            SRC_C_COND:
            begin
                load_dvd = {cond_c, {(SUM_W-COND_W){1'b0}}};
                load_cnt = CNT_W'(COND_W);
            end
            SRC_CUR:
            begin
                load_dvd = {RAW_W'(current_reg), {(SUM_W-RAW_W){1'b0}}};
                load_cnt = CNT_W'(RAW_W);
            end
            SRC_PROD:
            begin
                load_dvd = {prod_reg, {(SUM_W-PROD_W){1'b0}}};
                load_cnt = CNT_W'(PROD_W);
            end
            SRC_VALUE:
            begin
                load_dvd = {value_reg, {(SUM_W-RAW_W){1'b0}}};
                load_cnt = CNT_W'(RAW_W);
            end
            SRC_SEED:
            begin
                load_dvd = sum_new;
                load_cnt = CNT_W'(SUM_W);
            end
        endcase
    end

    // final (product mod m + c) mod m on add; the remainder itself on fin
    logic [COND_W-1:0] fin_sum, fin_red;

    always_comb
    begin
        fin_sum = {1'b0, rem_reg} + {1'b0, c_reg};
        fin_red = (fin_sum >= m_ext) ? fin_sum - m_ext : fin_sum;
        unique case (cmd.dp_op)
            DP_ADD:  current_next = STATE_BITS'(fin_red[MOD_W-1:0]);
            DP_FIN:  current_next = STATE_BITS'(rem_reg);
            default: current_next = current_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            current_reg  <= '0;
            seed_sum_reg <= SUM_W'(1);
            pos_reg      <= '0;
        end
        else
        begin
            if (cmd.div_start)
                cnt_reg <= load_cnt;
            else if (cnt_reg != '0)
                cnt_reg <= cnt_next;
            current_reg <= current_next;
            if (cmd.dp_op == DP_SEED)
            begin
                if (last_reg)
                begin
                    seed_sum_reg <= SUM_W'(1);
                    pos_reg      <= '0;
                end
                else
                begin
                    seed_sum_reg <= sum_new;
                    pos_reg      <= pos_new;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            value_reg <= value;
            char_reg  <= character;
            first_reg <= first;
            last_reg  <= last;
        end
        if (cmd.div_start)
        begin
            dvd_reg <= load_dvd;
            rem_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
        if (cmd.dp_op == DP_SAVE_A)
            a_reg <= rem_reg;
        if (cmd.dp_op == DP_SAVE_C)
            c_reg <= rem_reg;
        if (cmd.dp_op == DP_MUL)
            prod_reg <= a_reg * rem_reg;
        if (cmd.out_load)
            number_reg <= NUM_W'(current_reg);
    end

    assign number        = number_reg;
    assign stat.div_done = (cnt_reg == '0);
    assign stat.last     = last_reg;

    `LCGC_ASSERT_IMP(a_div_start_idle, cmd.div_start, cnt_reg == '0)
    `LCGC_ASSERT_NXT(a_div_count, (cnt_reg != '0) && !cmd.div_start, cnt_reg == $past(cnt_reg) - CNT_W'(1))
    `LCGC_ASSERT_NXT(a_seed_restart, (cmd.dp_op == DP_SEED) && last_reg, (seed_sum_reg == SUM_W'(1)) && (pos_reg == '0))

endmodule

`default_nettype wire

@@ src/lcg_with_conditioned_params_core.sv @@
// lcg core top: apb register file, controller and datapath; depends on lcgc_pkg
// a next number runs six serial remainders of 32, 18, 32, 18, 32 and 34
// dividend bits, a load one of 32 bits, a last seed char one of 48 bits
// one word in flight; the next is taken once the last is in the output register
// rst_n asynchronous: state 0, seed sum 1, position 0, registers to reset values
`default_nettype none

module lcg_with_conditioned_params_core
    import lcgc_pkg::*;
#(
    parameter int STATE_BITS = STATE_BITS_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [OP_W-1:0]   op,
    input  wire logic [RAW_W-1:0]  value,
    input  wire logic [CHAR_W-1:0] character,
    input  wire logic              first,
    input  wire logic              last,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [NUM_W-1:0]       number
);

    logic [MOD_W-1:0] modulus_reg;
    logic [RAW_W-1:0] factor_reg;
    logic [RAW_W-1:0] incr_reg;
    logic [1:0]       reg_idx;
    logic             wr_en;

    cmd_t  cmd;
    stat_t stat;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= MOD_RESET;
            factor_reg  <= FACTOR_RESET;
            incr_reg    <= INCR_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_MODULUS: modulus_reg <= pwdata[MOD_W-1:0];
                REG_FACTOR:  factor_reg  <= pwdata;
                REG_INCR:    incr_reg    <= pwdata;
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_MODULUS: prdata = {{(DATA_W-MOD_W){1'b0}}, modulus_reg};
            REG_FACTOR:  prdata = factor_reg;
            REG_INCR:    prdata = incr_reg;
            default:     prdata = '0;
        endcase
    end

    lcgc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    lcgc_datapath #(
        .STATE_BITS (STATE_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .modulus       (modulus_reg),
        .factor_raw    (factor_reg),
        .increment_raw (incr_reg),
        .value         (value),
        .character     (character),
        .first         (first),
        .last          (last),
        .number        (number)
    );

endmodule

`default_nettype wire

@@ bench/lcg_with_conditioned_params_core_tb.sv @@
// self-checking bench for lcg_with_conditioned_params_core: random and directed words, apb
// register phases, inline generator predictor; depends on lcgc_pkg and the core rtl
module lcg_with_conditioned_params_core_tb
    import lcgc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STATE_BITS = STATE_BITS_DEF;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int QUIET_LIMIT = 5000;
    localparam int HOLD_CYCLES = 700;
    localparam int LONG_STRING = 12;
    localparam longint unsigned SUM_MASK = 64'h0000_FFFF_FFFF_FFFF;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [RAW_W-1:0]  value;
        logic [CHAR_W-1:0] character;
        logic              first;
        logic              last;
    } word_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [OP_W-1:0]   op = '0;
    logic [RAW_W-1:0]  value = '0;
    logic [CHAR_W-1:0] character = '0;
    logic              first = 1'b0;
    logic              last = 1'b0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [NUM_W-1:0]  number;

    // generator copy: registers and state
    logic [MOD_W-1:0]  cfg_modulus = MOD_RESET;
    logic [RAW_W-1:0]  cfg_factor = FACTOR_RESET;
    logic [RAW_W-1:0]  cfg_incr = INCR_RESET;
    longint unsigned   gen_state = 0;
    longint unsigned   seed_total = 1;
    longint unsigned   seed_pos = 0;

    word_t             pending_words[$];
    logic [NUM_W-1:0]  expected_numbers[$];
    logic [NUM_W-1:0]  oldest_number;
    int                fail_count = 0;
    int                send_gap = 0;
    int                stall_left = 0;
    int                hold_left = 0;
    int                holds_asked = 0;
    int                holds_served = 0;
    int                quiet_cycles = 0;
    bit                calm = 1'b0;

    lcg_with_conditioned_params_core #(.STATE_BITS(STATE_BITS)) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .value     (value),
        .character (character),
        .first     (first),
        .last      (last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .number    (number)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic longint unsigned active_modulus();
        longint unsigned top;
        top = 64'd1 << STATE_BITS;
        if (cfg_modulus < 2)
            return 2;
        if (64'(cfg_modulus) > top)
            return top;
        return 64'(cfg_modulus);
    endfunction

    // multiplier forced to 1 mod 4, then lifted above the floor
    function automatic longint unsigned conditioned_factor(input longint unsigned m);
        longint unsigned t;
        longint unsigned a;
        t = cfg_factor % m;
        case (t & 3)
            0: a = (t + 1) % m;
            1: a = t;
            2: a = (t + 3) % m;
            default: a = (t + 2) % m;
        endcase
        if (a < FactorFloor)
            a += FactorFloor;
        return a;
    endfunction

    function automatic longint unsigned conditioned_increment(input longint unsigned m);
        longint unsigned t;
        longint unsigned c;
        t = cfg_incr % m;
        c = (t & 1) ? t : (t + 1) % m;
        if (c < IncrFloor)
            c += IncrFloor;
        return c;
    endfunction

    function automatic logic [NUM_W-1:0] advance_generator(input logic [OP_W-1:0] op_i,
                                                           input logic [RAW_W-1:0] value_i,
                                                           input logic [CHAR_W-1:0] char_i,
                                                           input logic first_i,
                                                           input logic last_i);
        longint unsigned m;
        longint unsigned a;
        longint unsigned c;
        longint unsigned mag;
        m = active_modulus();
        case (op_i)
            OP_NEXT:
            begin
                a = conditioned_factor(m) % m;
                c = conditioned_increment(m) % m;
                gen_state = ((a * (gen_state % m)) % m + c) % m;
            end
            OP_LOAD:
                gen_state = value_i % m;
            OP_SEED:
            begin
                mag = char_i[CHAR_W-1] ? 64'd256 - char_i : 64'(char_i);
                if (first_i)
                begin
                    seed_total = 1;
                    seed_pos = 0;
                end
                seed_total = (seed_total + (seed_pos + 1) * mag) & SUM_MASK;
                if (seed_pos < 65535)
                    seed_pos++;
                if (last_i)
                begin
                    gen_state = seed_total % m;
                    seed_total = 1;
                    seed_pos = 0;
                end
            end
            default: ;
        endcase
        gen_state &= (64'd1 << STATE_BITS) - 1;
        return NUM_W'(gen_state);
    endfunction

    // driver: one word on the bus until it is taken
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
                expected_numbers.push_back(advance_generator(op, value, character, first, last));
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (!calm && $urandom_range(0, 15) == 0)
                begin
                    send_gap <= $urandom_range(0, 12);
                    in_valid <= 1'b0;
                end
                else if (pending_words.size() != 0)
                begin
                    in_valid <= 1'b1;
                    op <= pending_words[0].op;
                    value <= pending_words[0].value;
                    character <= pending_words[0].character;
                    first <= pending_words[0].first;
                    last <= pending_words[0].last;
                    void'(pending_words.pop_front());
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: checks numbers and throttles out_ready
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_numbers.size() == 0)
                begin
                    $error("unexpected word: number %0d", number);
                    fail_count++;
                end
                else
                begin
                    oldest_number = expected_numbers.pop_front();
                    if (number !== oldest_number)
                    begin
                        $error("number mismatch: expected %0d, actual %0d", oldest_number, number);
                        fail_count++;
                    end
                end
            end
            if (holds_served != holds_asked)
            begin
                holds_served <= holds_asked;
                hold_left <= HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                out_ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 15) == 0)
            begin
                stall_left <= $urandom_range(0, 12);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic write_register(input logic [1:0] index, input logic [DATA_W-1:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (index)
            REG_MODULUS: cfg_modulus = data[MOD_W-1:0];
            REG_FACTOR:  cfg_factor = data;
            REG_INCR:    cfg_incr = data;
            default: ;
        endcase
    endtask

    task automatic push_word(input logic [OP_W-1:0] op_i, input logic [RAW_W-1:0] value_i,
                             input logic [CHAR_W-1:0] char_i, input logic first_i,
                             input logic last_i);
        word_t w;
        w.op = op_i;
        w.value = value_i;
        w.character = char_i;
        w.first = first_i;
        w.last = last_i;
        pending_words.push_back(w);
    endtask

    function automatic logic [CHAR_W-1:0] random_char();
        logic [CHAR_W-1:0] corners[4];
        corners = '{8'h00, 8'h7F, 8'h80, 8'hFF};
        if ($urandom_range(0, 3) == 0)
            return corners[2'($urandom_range(0, 3))];
        return CHAR_W'($urandom_range(0, 255));
    endfunction

    task automatic queue_random_items(input int count);
        int added;
        int kind;
        int len;
        added = 0;
        while (added < count)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 45)
            begin
                push_word(OP_NEXT, $urandom, random_char(), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
                added++;
            end
            else if (kind < 60)
            begin
                push_word(OP_LOAD, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 70000),
                          random_char(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                added++;
            end
            else if (kind < 85)
            begin
                // well-formed seed string
                len = $urandom_range(1, 8);
                for (int i = 0; i < len; i++)
                    push_word(OP_SEED, $urandom, random_char(), i == 0, i == len - 1);
                added += len;
            end
            else if (kind < 95)
            begin
                push_word(OP_SEED, $urandom, random_char(), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
                added++;
            end
            else
            begin
                push_word(OP_UNUSED, $urandom, random_char(), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
                added++;
            end
        end
    endtask

    // sampled away from the active edge so every bus update has settled
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_words.size() != 0 || in_valid || !in_ready ||
               expected_numbers.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic run_phase(input logic [DATA_W-1:0] modulus_w,
                             input logic [DATA_W-1:0] factor_w,
                             input logic [DATA_W-1:0] incr_w, input int count);
        write_register(REG_MODULUS, modulus_w);
        write_register(REG_FACTOR, factor_w);
        write_register(REG_INCR, incr_w);
        queue_random_items(count);
        wait_idle();
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset registers, corner values and seed flag combinations
        push_word(OP_NEXT, 32'h0, 8'h00, 1'b0, 1'b0);
        push_word(OP_NEXT, 32'hFFFF_FFFF, 8'hFF, 1'b1, 1'b1);
        push_word(OP_LOAD, 32'hFFFF_FFFF, 8'h00, 1'b0, 1'b0);
        push_word(OP_NEXT, 32'h0, 8'h00, 1'b0, 1'b0);
        push_word(OP_LOAD, 32'h0, 8'hFF, 1'b1, 1'b1);
        push_word(OP_UNUSED, 32'hA5A5_5A5A, 8'hC3, 1'b1, 1'b1);
        push_word(OP_SEED, 32'h0, 8'h80, 1'b1, 1'b0);
        push_word(OP_SEED, 32'h0, 8'hFF, 1'b0, 1'b0);
        push_word(OP_SEED, 32'h0, 8'h7F, 1'b0, 1'b0);
        push_word(OP_SEED, 32'h0, 8'h00, 1'b0, 1'b1);
        // string after a terminator starts fresh without a first flag
        push_word(OP_SEED, 32'h0, 8'h01, 1'b0, 1'b0);
        push_word(OP_SEED, 32'h0, 8'h81, 1'b0, 1'b1);
        push_word(OP_SEED, 32'h0, 8'h81, 1'b1, 1'b1);
        push_word(OP_SEED, 32'h0, 8'h10, 1'b0, 1'b0);
        push_word(OP_SEED, 32'h0, 8'h20, 1'b1, 1'b0);
        push_word(OP_SEED, 32'h0, 8'hF0, 1'b0, 1'b1);
        push_word(OP_LOAD, 32'h1234_5678, 8'h00, 1'b0, 1'b0);
        push_word(OP_NEXT, 32'h0, 8'h00, 1'b0, 1'b0);
        queue_random_items(70);
        wait_idle();

        run_phase(32'd0, 32'd0, 32'd0, 70);
        run_phase(32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 60);
        run_phase(32'd2, $urandom, $urandom, 50);
        run_phase(32'd65536, 32'hFFFF_FFFF, 32'd0, 80);
        run_phase(32'h1_FFFF, $urandom, $urandom, 60);
        run_phase(32'd65537, $urandom_range(0, 8000), $urandom_range(0, 6000), 60);
        run_phase($urandom_range(3, 40), $urandom, $urandom, 60);
        run_phase($urandom_range(3000, 9000), $urandom, $urandom, 60);

        // receiver holds off while the sender keeps offering
        write_register(REG_MODULUS, $urandom_range(2, 65536));
        write_register(REG_FACTOR, $urandom);
        write_register(REG_INCR, $urandom);
        holds_asked++;
        queue_random_items(70);
        wait_idle();

        // one longer string at the full modulus, then a step from its result
        write_register(REG_MODULUS, 32'd65536);
        for (int i = 0; i < LONG_STRING; i++)
            push_word(OP_SEED, $urandom, random_char(), i == 0, i == LONG_STRING - 1);
        push_word(OP_NEXT, $urandom, random_char(), 1'b0, 1'b0);
        wait_idle();

        calm = 1'b1;
        run_phase($urandom_range(2, 65536), $urandom, $urandom, 80);

        repeat (200) @(posedge clk);
        if (expected_numbers.size() != 0)
        begin
            $error("%0d expected numbers never arrived", expected_numbers.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+src
src/lcgc_pkg.sv
src/lcgc_ctrl.sv
src/lcgc_datapath.sv
src/lcg_with_conditioned_params_core.sv
bench/lcg_with_conditioned_params_core_tb.sv
